@@ sv/kvt_pkg.sv @@
// Shared types and constants for the key/value table set/get unit.
// Depends on nothing; used by kvt_cell and key_value_table_set_get_unit.
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

   localparam int unsigned KEY_W   = 64;
   localparam int unsigned VALUE_W = 64;
   localparam int unsigned COUNT_W = 5;

   typedef enum logic [1:0] {
      ST_UPDATED  = 2'd0,
      ST_INSERTED = 2'd1,
      ST_FULL     = 2'd2,
      ST_GET      = 2'd3
   } kvt_status_type;

   typedef enum logic {
      CMD_SET = 1'b0,
      CMD_GET = 1'b1
   } kvt_command_type;

   typedef struct packed {
      logic                  valid;
      kvt_command_type       command;
      logic [KEY_W-1:0]      key;
      logic [VALUE_W-1:0]    value;
      logic                  hit;
      logic                  placed;
      logic [VALUE_W-1:0]    value_out;
   } kvt_token_type;

endpackage : kvt_pkg

`default_nettype wire

@@ sv/key_value_table_set_get_unit.sv @@
// Top level of the key/value table set/get unit: a chain of kvt_cell
// instances and the registered result stage. Depends on kvt_pkg, kvt_cell.
`timescale 1ns / 1ps
`default_nettype none

// The table is a chain of CAPACITY cells, each holding one key/value pair.
// A transaction walks the chain one cell per cycle, comparing its key with
// each held entry, updating or reading it on a match and claiming the first
// empty cell for a new key. A result passes through every cell and then
// the registered result stage. Since every cell is a pipeline stage a new
// request can be accepted every cycle while the chain is not stalled, so
// throughput is one transaction per cycle. The whole chain advances
// together; it stalls only while a result sits in the output register and
// rsp_ready is low. entry_count gives the low five bits of the entry count.

module key_value_table_set_get_unit #(
   parameter int unsigned CAPACITY = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic                              req_command,
   input  wire logic [kvt_pkg::KEY_W-1:0]         req_lookup_key,
   input  wire logic [kvt_pkg::VALUE_W-1:0]       req_value_in,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [1:0]                             rsp_status,
   output logic                                   rsp_hit,
   output logic [kvt_pkg::VALUE_W-1:0]            rsp_value_out,
   output logic [kvt_pkg::COUNT_W-1:0]            rsp_entry_count
);

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

   kvt_pkg::kvt_token_type            tok [CAPACITY+1];
   logic [CNT_W-1:0]                  cnt [CAPACITY+1];
   logic                              enable;
   kvt_pkg::kvt_token_type            head;
   kvt_pkg::kvt_token_type            last;
   kvt_pkg::kvt_status_type           status_in;
   logic [CNT_W+kvt_pkg::COUNT_W-1:0] cnt_ext;

   logic                              rsp_valid_ff;
   kvt_pkg::kvt_status_type           status_ff;
   logic                              hit_ff;
   logic [kvt_pkg::VALUE_W-1:0]       value_out_ff;
   logic [kvt_pkg::COUNT_W-1:0]       count_ff;

   assign enable    = !rsp_valid_ff || rsp_ready;
   assign req_ready = enable;

   always_comb begin
      head         = '0;
      head.valid   = req_valid;
      head.command = kvt_pkg::kvt_command_type'(req_command);
      head.key     = req_lookup_key;
      head.value   = req_value_in;
   end

   assign tok[0] = head;
   assign cnt[0] = '0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      kvt_cell #(
         .CNT_W (CNT_W)
      ) u_cell (
         .clock  (clock),
         .reset  (reset),
         .enable (enable),
         .tok_i  (tok[i]),
         .cnt_i  (cnt[i]),
         .tok_o  (tok[i+1]),
         .cnt_o  (cnt[i+1])
      );
   end

   assign last    = tok[CAPACITY];
   assign cnt_ext = {{kvt_pkg::COUNT_W{1'b0}}, cnt[CAPACITY]};

   always_comb begin
      priority if (last.command == kvt_pkg::CMD_GET) begin
         status_in = kvt_pkg::ST_GET;
      end else if (last.hit) begin
         status_in = kvt_pkg::ST_UPDATED;
      end else if (last.placed) begin
         status_in = kvt_pkg::ST_INSERTED;
      end else begin
         status_in = kvt_pkg::ST_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= last.valid;
         status_ff    <= status_in;
         hit_ff       <= last.hit;
         value_out_ff <= last.value_out;
         count_ff     <= cnt_ext[kvt_pkg::COUNT_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_hit         = hit_ff;
   assign rsp_value_out   = value_out_ff;
   assign rsp_entry_count = count_ff;

   // The entry count at the chain end never exceeds the capacity.
   assert property (@(posedge clock) disable iff (reset)
      last.valid |-> ({1'b0, cnt[CAPACITY]} <= (CNT_W+1)'(CAPACITY)))
      else $error("Entry count exceeds capacity.");

   // A value is returned only for a get that hit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_value_out != '0)) |->
         ((rsp_status == kvt_pkg::ST_GET) && rsp_hit))
      else $error("Value returned without a get hit.");

   // Insertions and dropped pairs never report a hit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_status == kvt_pkg::ST_INSERTED) ||
                     (rsp_status == kvt_pkg::ST_FULL))) |-> !rsp_hit)
      else $error("Hit flagged on insert or full status.");

endmodule : key_value_table_set_get_unit

`default_nettype wire

@@ sv/kvt_cell.sv @@
// One storage cell of the table chain: holds one key/value pair and its
// occupancy, and forwards the passing transaction to the next cell.
// Depends on kvt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module kvt_cell #(
   parameter int unsigned CNT_W = 5
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  enable,
   input  wire kvt_pkg::kvt_token_type tok_i,
   input  wire logic [CNT_W-1:0]      cnt_i,
   output kvt_pkg::kvt_token_type     tok_o,
   output logic      [CNT_W-1:0]      cnt_o
);

   logic                              occ_ff;
   logic                              occ_in;
   logic [kvt_pkg::KEY_W-1:0]         key_ff;
   logic [kvt_pkg::KEY_W-1:0]         key_in;
   logic [kvt_pkg::VALUE_W-1:0]       value_ff;
   logic [kvt_pkg::VALUE_W-1:0]       value_in;
   kvt_pkg::kvt_token_type            tok_ff;
   kvt_pkg::kvt_token_type            tok_in;
   logic [CNT_W-1:0]                  cnt_ff;
   logic [CNT_W-1:0]                  cnt_in;
   logic                              match;

   always_comb begin
      tok_in   = tok_i;
      occ_in   = occ_ff;
      key_in   = key_ff;
      value_in = value_ff;
      match    = occ_ff && (key_ff == tok_i.key);
      if (tok_i.valid) begin
         if (match) begin
            tok_in.hit = 1'b1;
            if (tok_i.command == kvt_pkg::CMD_GET) begin
               tok_in.value_out = value_ff;
            end else begin
               value_in = tok_i.value;
            end
         end else if (!occ_ff && (tok_i.command == kvt_pkg::CMD_SET) &&
                      !tok_i.hit && !tok_i.placed) begin
            occ_in        = 1'b1;
            key_in        = tok_i.key;
            value_in      = tok_i.value;
            tok_in.placed = 1'b1;
         end
      end
      cnt_in = cnt_i + CNT_W'(occ_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else if (enable) begin
         occ_ff   <= occ_in;
         key_ff   <= key_in;
         value_ff <= value_in;
         tok_ff   <= tok_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign tok_o = tok_ff;
   assign cnt_o = cnt_ff;

   // An entry once filled is never released.
   assert property (@(posedge clock) disable iff (reset) !$fell(occ_ff))
      else $error("Occupied cell became empty.");

   // A transaction that has found its key is never placed as a new entry.
   assert property (@(posedge clock) disable iff (reset)
      tok_ff.valid |-> !(tok_ff.hit && tok_ff.placed))
      else $error("Transaction both hit and placed.");

   // A filled cell that is not stalled keeps its key.
   assert property (@(posedge clock) disable iff (reset)
      (occ_ff && enable) |=> $stable(key_ff))
      else $error("Key of an occupied cell changed.");

endmodule : kvt_cell

`default_nettype wire
